>>> rtl/core/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared types, codes and constants of the playout lag adapter.
// ----------------------------------------------------------------------------
package pla_pkg;

	// default lag fraction width (q16.16 lag)
	localparam int LAG_FRAC_DEF = 16;

	// channel widths
	localparam int IN_DATA_W  = 112;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 112;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SMOOTHING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRACE_FRAMES      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_RATE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXTRA         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FORECAST_MODE     = 3'd6;

	// register reset values
	localparam logic [9:0]  RST_EXPECTED_INTERVAL = 10'd1;
	localparam logic [16:0] RST_FLOOR_SMOOTHING   = 17'd6554;
	localparam logic [16:0] RST_ADAPT_RATE        = 17'd6554;
	localparam logic [7:0]  RST_GRACE_FRAMES      = 8'd2;
	localparam logic [16:0] RST_GROWTH_RATE       = 17'd32768;
	localparam logic [23:0] RST_MAX_EXTRA         = 24'd262144;

	// unity in q1.16
	localparam logic [16:0] Q16_ONE = 17'd65536;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = 50;

	// operation codes
	typedef enum logic [1:0] {
		OP_DILATE = 2'd0,
		OP_PLACE  = 2'd1,
		OP_SETTLE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLOOR,
		ST_MUL1,
		ST_WB1,
		ST_MUL2,
		ST_WB2,
		ST_CALC,
		ST_OUT
	} state_t;

	// request to the shared multiplier: signed a times unsigned b
	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	// a factor above unity acts as unity
	function automatic logic [16:0] clamp_q16(input logic [16:0] k);
		return (k > Q16_ONE) ? Q16_ONE : k;
	endfunction

endpackage

>>> rtl/core/pla_mac.sv
// ----------------------------------------------------------------------------
// pla_mac
// Shared multiplier: signed 33-bit operand times unsigned 17-bit factor,
// product registered.
// ----------------------------------------------------------------------------
module pla_mac (
	input  logic                                 clk,
	input  pla_pkg::mul_req_t                    req,
	output logic signed [pla_pkg::MUL_P_W-1:0]   prod
);
	import pla_pkg::*;

	logic signed [MUL_A_W+MUL_B_W:0] full;
	logic signed [MUL_P_W-1:0]       prod_s1;

	// signed multiply, factor zero-extended
	assign full = $signed(req.a) * $signed({1'b0, req.b});

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= full[MUL_P_W-1:0];
	end

	assign prod = prod_s1;

endmodule

>>> rtl/core/playout_lag_adapter.sv
// ----------------------------------------------------------------------------
// playout_lag_adapter
// Adaptive playout lag behind a display clock: floor smoothing, starve
// driven growth, relaxing, settling, placement and effective tick query.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: operation
//                                              tdata: offsets, span, clock
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: tick, fraction, lag, floor
// cfg       in   cfg_we (no wait)              cfg_index, cfg_wdata
//
// dilate makes two dependent passes through the one shared multiplier (floor
// smoothing, then growth or relax), each a multiply and a write-back state,
// between the floor and output states. settle goes from floor to output, place
// and query through calc to output; a new beat is taken only in idle.
// arst_n clears lag, floor, starve count and control; registers take their reset
// values. A result waiting on m_axis does not block the next input beat; the
// sequencer holds in its output state only while that slot is full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module playout_lag_adapter #(
	parameter int LAG_FRAC_BITS = pla_pkg::LAG_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// offset_now, offset_advised, frame_span, is_starving, clock_tick,
	// clock_fraction, is_bracketed, zero pad
	input  logic [pla_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// operation
	input  logic [pla_pkg::IN_USER_W-1:0]     s_axis_tuser,
	// master side
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// shown_tick, shown_fraction, lag_now, floor_now
	output logic [pla_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// configuration
	input  logic                              cfg_we,
	input  logic [pla_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pla_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import pla_pkg::*;

	localparam int F     = LAG_FRAC_BITS;
	localparam int SH_W  = (17 + F > 33) ? 17 + F : 33;
	localparam int TW    = 34 + F;
	localparam int INC_W = F + 9;
	localparam int MX_W  = F + 8;

	// configuration registers
	logic [9:0]  exp_int_q;
	logic [16:0] fsmooth_q;
	logic [16:0] arate_q;
	logic [7:0]  grace_q;
	logic [16:0] grow_q;
	logic [23:0] maxx_q;
	logic        fcast_q;

	// captured input beat
	op_t                op_q;
	logic [15:0]        now_q;
	logic [15:0]        adv_q;
	logic [23:0]        span_q;
	logic               starv_q;
	logic signed [31:0] ctick_q;
	logic [15:0]        cfrac_q;
	logic               brk_q;

	// block state
	logic [31:0] lag_q;
	logic [31:0] sfl_q;
	logic [15:0] starve_q;
	logic [31:0] rf_q;

	// pending result and output slot
	logic [31:0]           res_tick_q;
	logic [15:0]           res_frac_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	state_t state_q, state_d;
	logic   accept;
	logic   load_out;

	// datapath wires
	logic [16:0]               pad;
	logic signed [18:0]        need;
	logic [SH_W-1:0]           need_sh;
	logic [31:0]               rf_c;
	mul_req_t                  mreq;
	logic signed [MUL_P_W-1:0] prod;
	logic                      grow_c;
	logic [INC_W-1:0]          inc;
	logic [MX_W+15:0]          maxx_w;
	logic [33:0]               grown;
	logic [33:0]               cap;
	logic [33:0]               lag_min;
	logic [F+15:0]             cfrac_w;
	logic [TW-1:0]             t_val;
	logic [F+15:0]             fr_w;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign load_out      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_int_q <= RST_EXPECTED_INTERVAL;
			fsmooth_q <= RST_FLOOR_SMOOTHING;
			arate_q   <= RST_ADAPT_RATE;
			grace_q   <= RST_GRACE_FRAMES;
			grow_q    <= RST_GROWTH_RATE;
			maxx_q    <= RST_MAX_EXTRA;
			fcast_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPECTED_INTERVAL: exp_int_q <= cfg_wdata[9:0];
				CFG_FLOOR_SMOOTHING:   fsmooth_q <= cfg_wdata[16:0];
				CFG_ADAPT_RATE:        arate_q   <= cfg_wdata[16:0];
				CFG_GRACE_FRAMES:      grace_q   <= cfg_wdata[7:0];
				CFG_GROWTH_RATE:       grow_q    <= cfg_wdata[16:0];
				CFG_MAX_EXTRA:         maxx_q    <= cfg_wdata[23:0];
				CFG_FORECAST_MODE:     fcast_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// raw lag floor from the captured offsets
	always_comb begin
		pad     = (adv_q > now_q) ? {1'b0, adv_q - now_q} : 17'd0;
		need    = $signed(19'(exp_int_q)) + 19'sd1 + $signed(19'(pad))
		        - $signed(19'(now_q));
		need_sh = SH_W'(need[16:0]) << F;
		if (fcast_q || need[18]) begin
			rf_c = 32'd0;
		end else if (|need_sh[SH_W-1:32]) begin
			rf_c = 32'hFFFF_FFFF;
		end else begin
			rf_c = need_sh[31:0];
		end
	end

	// growth once the starve count reaches the grace count
	assign grow_c = (starve_q >= 16'(grace_q));

	// operand selection for the shared multiplier
	always_comb begin
		mreq.a = '0;
		mreq.b = '0;
		case (state_q)
			ST_MUL1: begin
				mreq.a = {1'b0, rf_q} - {1'b0, sfl_q};
				mreq.b = clamp_q16(fsmooth_q);
			end
			ST_MUL2: begin
				if (grow_c) begin
					mreq.a = MUL_A_W'(span_q);
					mreq.b = grow_q;
				end else begin
					mreq.a = {1'b0, sfl_q} - {1'b0, lag_q};
					mreq.b = clamp_q16(arate_q);
				end
			end
			default: ;
		endcase
	end

	pla_mac u_mac (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// growth step capped at floor plus the maximum extra
	always_comb begin
		inc     = prod[40:32-F];
		maxx_w  = {maxx_q, {F{1'b0}}};
		grown   = 34'(lag_q) + 34'(inc);
		cap     = 34'(sfl_q) + 34'(maxx_w[MX_W+15:16]);
		lag_min = (grown < cap) ? grown : cap;
	end

	// clock minus lag for place and query
	always_comb begin
		cfrac_w = {cfrac_q, {F{1'b0}}};
		t_val   = ({{(TW-32){ctick_q[31]}}, ctick_q} << F) - TW'(lag_q);
		if (op_q == OP_PLACE) begin
			t_val = t_val + TW'(cfrac_w[F+15:16]);
		end
		fr_w = {t_val[F-1:0], 16'd0};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(s_axis_tuser) inside {OP_PLACE, OP_QUERY}) begin
						state_d = ST_CALC;
					end else begin
						state_d = ST_FLOOR;
					end
				end
			end
			ST_FLOOR: state_d = (op_q == OP_SETTLE) ? ST_OUT : ST_MUL1;
			ST_MUL1:  state_d = ST_WB1;
			ST_WB1:   state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_WB2;
			ST_WB2:   state_d = ST_OUT;
			ST_CALC:  state_d = ST_OUT;
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(s_axis_tuser);
			now_q   <= s_axis_tdata[15:0];
			adv_q   <= s_axis_tdata[31:16];
			span_q  <= s_axis_tdata[55:32];
			starv_q <= s_axis_tdata[56];
			ctick_q <= s_axis_tdata[88:57];
			cfrac_q <= s_axis_tdata[104:89];
			brk_q   <= s_axis_tdata[105];
		end
	end

	// lag, floor and starve count updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_q    <= '0;
			sfl_q    <= '0;
			starve_q <= '0;
		end else begin
			case (state_q)
				ST_FLOOR: begin
					if (op_q == OP_SETTLE) begin
						lag_q    <= rf_c;
						sfl_q    <= rf_c;
						starve_q <= '0;
					end
				end
				ST_WB1: begin
					sfl_q <= sfl_q + prod[47:16];
					if (!starv_q) begin
						starve_q <= '0;
					end else if (starve_q != 16'hFFFF) begin
						starve_q <= starve_q + 16'd1;
					end
				end
				ST_WB2: begin
					if (grow_c) begin
						lag_q <= (|lag_min[33:32]) ? 32'hFFFF_FFFF : lag_min[31:0];
					end else begin
						lag_q <= lag_q + prod[47:16];
					end
				end
				ST_CALC: begin
					if (op_q == OP_PLACE && brk_q) begin
						lag_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// raw floor and pending result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FLOOR: begin
				rf_q       <= rf_c;
				res_tick_q <= '0;
				res_frac_q <= '0;
			end
			ST_CALC: begin
				if (op_q == OP_PLACE && brk_q) begin
					res_tick_q <= (ctick_q > 32'sd0) ? 32'(ctick_q - 32'sd1) : 32'd0;
					res_frac_q <= cfrac_q;
				end else begin
					res_tick_q <= t_val[F+31:F];
					res_frac_q <= (op_q == OP_PLACE) ? fr_w[F+15:F] : 16'd0;
				end
			end
			default: ;
		endcase
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {sfl_q, lag_q, res_frac_q, res_tick_q};
		end
	end

	// a dilate or settle beat goes to the floor step first
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_axis_tuser == OP_DILATE || s_axis_tuser == OP_SETTLE)
		|=> state_q == ST_FLOOR)
		else $error("dilate or settle beat did not enter floor step");

	// a new result only comes out of the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output state");

	// a bracketed place clears the lag
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC && op_q == OP_PLACE && brk_q |=> lag_q == 32'd0)
		else $error("bracketed place left a lag");

	// settle snaps lag and floor together and clears the starve count
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLOOR && op_q == OP_SETTLE
		|=> lag_q == sfl_q && starve_q == 16'd0)
		else $error("settle did not snap lag to floor");

	// a dilate runs from the first multiply state through both passes to the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |-> ##4 state_q == ST_OUT)
		else $error("dilate sequence broken");

endmodule
